/* rtl/core/hrp_pkg.sv */
// package for the hillshade relief pixel block: widths, constants, payload types
`timescale 1ns / 1ps
`default_nettype none
package hrp_pkg;

	// height field width of the input transaction
	localparam int HEIGHT_BITS = 16;

	// internal widths
	localparam int SUM_W      = 20;   // signed sx, sy
	localparam int ABS_W      = 20;   // |sx + sy|
	localparam int NN_W       = 39;   // squared norm of the summed normal
	localparam int NUM_W      = 64;   // dividend, wraps at 64 bits
	localparam int QUO_W      = 32;   // quotient width
	localparam int DIV_STEPS  = QUO_W;
	localparam int SQRT_STEPS = QUO_W / 2;
	localparam int MAG_W      = QUO_W / 2;
	localparam int SHADE_W    = 15;

	localparam logic [SHADE_W-1:0] SHADE_HALF = 15'd8192;
	localparam logic [SHADE_W-1:0] SHADE_ONE  = 15'd16384;

	// x / 10 as (x * RECIP10) >> 16, exact for x below 16384
	localparam logic [12:0] RECIP10 = 13'd6554;

	// configuration register indexes
	localparam logic CFG_SEA_LEVEL  = 1'b0;
	localparam logic CFG_SHADE_GAIN = 1'b1;

	localparam logic [15:0] SEA_LEVEL_RST  = 16'd32768;
	localparam logic [7:0]  SHADE_GAIN_RST = 8'd35;

	// tint colours, channel order red, green, blue, alpha
	localparam logic [7:0] DARK_TINT  [4] = '{8'h33, 8'h11, 8'h33, 8'hFF};
	localparam logic [7:0] LIGHT_TINT [4] = '{8'hFF, 8'hFF, 8'hCC, 8'hFF};

	typedef struct packed {
		logic [HEIGHT_BITS-1:0] center_height;
		logic [HEIGHT_BITS-1:0] west_height;
		logic [HEIGHT_BITS-1:0] east_height;
		logic [HEIGHT_BITS-1:0] north_height;
		logic [HEIGHT_BITS-1:0] south_height;
		logic [3:0]             neighbour_mask;
		logic [7:0]             src_red;
		logic [7:0]             src_green;
		logic [7:0]             src_blue;
		logic [7:0]             src_alpha;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} result_t;

	// side information that travels with each pixel down the pipe
	typedef struct packed {
		logic        sea;    // below sea level, colour passes through
		logic        flat;   // no neighbour pair, dot is zero
		logic        neg;    // dot product is negative
		logic [31:0] color;  // red, green, blue, alpha
	} meta_t;

	// bring a height to sixteen fraction bits
	function automatic logic [15:0] to_q16(input logic [HEIGHT_BITS-1:0] h);
		logic [HEIGHT_BITS+15:0] ext;
		ext = {h, 16'd0};
		return ext[HEIGHT_BITS +: 16];
	endfunction

endpackage
`default_nettype wire

/* rtl/core/hillshade_relief_pixel.sv */
// Hillshaded relief for one map pixel, one transaction per clock.
// Throughput: one pixel every cycle; busy stays low, the pipe never stalls.
// The depth is set by the 32-stage restoring divider and 16-stage square root.
// Reset clears all valid bits and loads sea_level 32768 and shade_gain 35.
`timescale 1ns / 1ps
`default_nettype none
module hillshade_relief_pixel (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire hrp_pkg::pixel_t pixel,
	output logic                 done,
	output hrp_pkg::result_t     result,
	input  wire logic            cfg_we,
	input  wire logic            cfg_index,
	input  wire logic [15:0]     cfg_data
);
	import hrp_pkg::*;

	// configuration registers
	logic [15:0] sea_level_q;
	logic [7:0]  shade_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sea_level_q  <= SEA_LEVEL_RST;
			shade_gain_q <= SHADE_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEA_LEVEL:  sea_level_q  <= cfg_data;
				CFG_SHADE_GAIN: shade_gain_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: differences and summed normal
	logic signed [17:0] dw, de, dn, ds;
	logic signed [SUM_W-1:0] sx_c, sy_c;
	logic [2:0] pairs_c;
	logic [15:0] hc;
	logic w, n, e, s;

	always_comb begin
		hc = to_q16(pixel.center_height);
		dw = $signed({2'b0, hc}) - $signed({2'b0, to_q16(pixel.west_height)});
		de = $signed({2'b0, hc}) - $signed({2'b0, to_q16(pixel.east_height)});
		dn = $signed({2'b0, hc}) - $signed({2'b0, to_q16(pixel.north_height)});
		ds = $signed({2'b0, hc}) - $signed({2'b0, to_q16(pixel.south_height)});
		w = pixel.neighbour_mask[0];
		n = pixel.neighbour_mask[1];
		e = pixel.neighbour_mask[2];
		s = pixel.neighbour_mask[3];
		sx_c = '0;
		sy_c = '0;
		pairs_c = '0;
		if (w && n) begin
			sx_c = sx_c - SUM_W'(dw); sy_c = sy_c - SUM_W'(dn); pairs_c = pairs_c + 3'd1;
		end
		if (w && s) begin
			sx_c = sx_c - SUM_W'(dw); sy_c = sy_c + SUM_W'(ds); pairs_c = pairs_c + 3'd1;
		end
		if (e && n) begin
			sx_c = sx_c + SUM_W'(de); sy_c = sy_c - SUM_W'(dn); pairs_c = pairs_c + 3'd1;
		end
		if (e && s) begin
			sx_c = sx_c + SUM_W'(de); sy_c = sy_c + SUM_W'(ds); pairs_c = pairs_c + 3'd1;
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7;
	logic signed [SUM_W-1:0] sx_s1, sy_s1;
	logic [2:0] pairs_s1, pairs_s2;
	logic [ABS_W-1:0] ua_s2;
	logic [SUM_W-2:0] usx_s2, usy_s2;
	logic [2*ABS_W-1:0] ua2_s3;
	logic [2*SUM_W-3:0] sx2_s3, sy2_s3;
	logic [5:0] pairs2_s3;
	logic [NUM_W-1:0] num_s4;
	logic [NN_W-1:0] nn_s4;

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	// front stages: sums, magnitudes, squares, dividend and divisor
	logic signed [SUM_W:0] sum_a;
	assign sum_a = $signed({sx_s1[SUM_W-1], sx_s1}) + $signed({sy_s1[SUM_W-1], sy_s1});

	logic [SUM_W-1:0] absx, absy;
	logic [SUM_W:0]   abs_a;
	assign absx  = sx_s1[SUM_W-1] ? SUM_W'(-sx_s1) : SUM_W'(sx_s1);
	assign absy  = sy_s1[SUM_W-1] ? SUM_W'(-sy_s1) : SUM_W'(sy_s1);
	assign abs_a = sum_a[SUM_W] ? (SUM_W+1)'(-sum_a) : (SUM_W+1)'(sum_a);

	always_ff @(posedge clk) begin
		meta_s1.sea   <= hc < sea_level_q;
		meta_s1.flat  <= pairs_c == 3'd0;
		meta_s1.neg   <= 1'b0;
		meta_s1.color <= {pixel.src_red, pixel.src_green, pixel.src_blue, pixel.src_alpha};
		sx_s1    <= sx_c;
		sy_s1    <= sy_c;
		pairs_s1 <= pairs_c;

		meta_s2.sea   <= meta_s1.sea;
		meta_s2.flat  <= meta_s1.flat;
		meta_s2.color <= meta_s1.color;
		meta_s2.neg   <= !sum_a[SUM_W] && (sum_a != '0);
		ua_s2    <= abs_a[ABS_W-1:0];
		usx_s2   <= absx[SUM_W-2:0];
		usy_s2   <= absy[SUM_W-2:0];
		pairs_s2 <= pairs_s1;

		meta_s3   <= meta_s2;
		ua2_s3    <= ua_s2 * ua_s2;
		sx2_s3    <= usx_s2 * usx_s2;
		sy2_s3    <= usy_s2 * usy_s2;
		pairs2_s3 <= pairs_s2 * pairs_s2;

		meta_s4 <= meta_s3;
		num_s4  <= {ua2_s3[NUM_W-29:0], 28'd0};
		nn_s4   <= NN_W'(sx2_s3) + NN_W'(sy2_s3) + {1'b0, pairs2_s3, 32'd0};
	end

	// restoring divider, one quotient bit per stage
	logic              div_v_q   [DIV_STEPS];
	meta_t             div_m_q   [DIV_STEPS];
	logic [NN_W-1:0]   div_rem_q [DIV_STEPS];
	logic [QUO_W-1:0]  div_lo_q  [DIV_STEPS];
	logic [QUO_W-1:0]  div_quo_q [DIV_STEPS];
	logic [NN_W-1:0]   div_nn_q  [DIV_STEPS];

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		logic             v_in;
		meta_t            m_in;
		logic [NN_W-1:0]  r_in, nn_in;
		logic [QUO_W-1:0] lo_in, q_in;
		logic [NN_W:0]    trial;
		logic             ge;
		if (g == 0) begin : g_first
			assign v_in  = v_s4;
			assign m_in  = meta_s4;
			assign r_in  = NN_W'(num_s4[NUM_W-1:QUO_W]);
			assign lo_in = num_s4[QUO_W-1:0];
			assign q_in  = '0;
			assign nn_in = nn_s4;
		end else begin : g_next
			assign v_in  = div_v_q[g-1];
			assign m_in  = div_m_q[g-1];
			assign r_in  = div_rem_q[g-1];
			assign lo_in = div_lo_q[g-1];
			assign q_in  = div_quo_q[g-1];
			assign nn_in = div_nn_q[g-1];
		end
		assign trial = {r_in, lo_in[QUO_W-1]};
		assign ge    = trial >= {1'b0, nn_in};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_q[g] <= 1'b0;
			end else begin
				div_v_q[g] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			div_m_q[g]   <= m_in;
			div_rem_q[g] <= ge ? NN_W'(trial - {1'b0, nn_in}) : trial[NN_W-1:0];
			div_lo_q[g]  <= {lo_in[QUO_W-2:0], 1'b0};
			div_quo_q[g] <= {q_in[QUO_W-2:0], ge};
			div_nn_q[g]  <= nn_in;
		end
	end

	// integer square root, one result bit per stage
	logic             sq_v_q   [SQRT_STEPS];
	meta_t            sq_m_q   [SQRT_STEPS];
	logic [QUO_W-1:0] sq_val_q [SQRT_STEPS];
	logic [QUO_W-1:0] sq_res_q [SQRT_STEPS];

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		localparam logic [QUO_W-1:0] BIT = QUO_W'(1) << (QUO_W - 2 - 2 * g);
		logic             v_in;
		meta_t            m_in;
		logic [QUO_W-1:0] val_in, res_in;
		logic [QUO_W:0]   trial;
		logic             ge;
		if (g == 0) begin : g_first
			assign v_in   = div_v_q[DIV_STEPS-1];
			assign m_in   = div_m_q[DIV_STEPS-1];
			assign val_in = div_quo_q[DIV_STEPS-1];
			assign res_in = '0;
		end else begin : g_next
			assign v_in   = sq_v_q[g-1];
			assign m_in   = sq_m_q[g-1];
			assign val_in = sq_val_q[g-1];
			assign res_in = sq_res_q[g-1];
		end
		assign trial = {1'b0, res_in} + {1'b0, BIT};
		assign ge    = {1'b0, val_in} >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_q[g] <= 1'b0;
			end else begin
				sq_v_q[g] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			sq_m_q[g]   <= m_in;
			sq_val_q[g] <= ge ? QUO_W'(val_in - trial[QUO_W-1:0]) : val_in;
			sq_res_q[g] <= ge ? (res_in >> 1) + BIT : res_in >> 1;
		end
	end

	// back stages: gain, shade clamp, tint, blend
	logic [MAG_W+7:0] prod_s5;
	logic [SHADE_W-1:0] f_s6, f_s7;
	logic low_s6, low_s7;
	logic [7:0] tint_s7 [4];
	logic [7:0] src_s6 [4];
	logic [7:0] src_s7 [4];
	logic [7:0] out_c [4];
	logic [MAG_W-1:0] mag;
	logic signed [MAG_W+9:0] t_raw;
	logic [SHADE_W-1:0] t_clamp;

	assign mag = sq_res_q[SQRT_STEPS-1][MAG_W-1:0];

	always_comb begin
		t_raw = meta_s5.neg ? $signed({11'd0, SHADE_HALF}) - $signed({2'b0, prod_s5})
		                    : $signed({11'd0, SHADE_HALF}) + $signed({2'b0, prod_s5});
		if (t_raw < 0)
			t_clamp = '0;
		else if (t_raw > $signed({11'd0, SHADE_ONE}))
			t_clamp = SHADE_ONE;
		else
			t_clamp = t_raw[SHADE_W-1:0];
	end

	for (genvar c = 0; c < 4; c++) begin : g_ch
		assign src_s6[c] = meta_s6.color[31-8*c -: 8];
		assign src_s7[c] = meta_s7.color[31-8*c -: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; done <= 1'b0;
		end else begin
			v_s5 <= sq_v_q[SQRT_STEPS-1];
			v_s6 <= v_s5; v_s7 <= v_s6; done <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		meta_s5 <= sq_m_q[SQRT_STEPS-1];
		prod_s5 <= sq_m_q[SQRT_STEPS-1].flat ? '0 : shade_gain_q * mag;

		meta_s6 <= meta_s5;
		low_s6  <= t_clamp < SHADE_HALF;
		f_s6    <= (t_clamp < SHADE_HALF) ? SHADE_W'({t_clamp, 1'b0})
		                                  : SHADE_W'({t_clamp, 1'b0} - {1'b0, SHADE_ONE});

		meta_s7 <= meta_s6;
		low_s7  <= low_s6;
		f_s7    <= f_s6;
	end

	// per channel tint and blend
	for (genvar c = 0; c < 4; c++) begin : g_blend
		logic [11:0] mix;
		logic [24:0] scaled;
		logic [7:0]  a, b;
		logic [23:0] acc;
		assign mix = low_s6 ? 12'(3 * src_s6[c]) + 12'(7 * DARK_TINT[c])
		                    : 12'(7 * src_s6[c]) + 12'(3 * LIGHT_TINT[c]);
		assign scaled = mix * RECIP10;
		always_ff @(posedge clk) begin
			tint_s7[c] <= scaled[23:16];
		end
		assign a   = low_s7 ? tint_s7[c] : src_s7[c];
		assign b   = low_s7 ? src_s7[c] : tint_s7[c];
		assign acc = a * (SHADE_ONE - f_s7) + b * f_s7;
		assign out_c[c] = meta_s7.sea ? src_s7[c] : acc[21:14];
	end

	// output register
	always_ff @(posedge clk) begin
		result <= {out_c[0], out_c[1], out_c[2], out_c[3]};
	end

endmodule
`default_nettype wire
